[src/mhba_pkg.sv]
// Shared constants and types for the multichannel half-buffer averager.
// Used by multichannel_half_buffer_averager_core.
package mhba_pkg;

    localparam int SAMPLE_W            = 12;
    localparam int CHAN_W              = 3;
    localparam int IN_TDATA_W          = 16;
    localparam int OUT_TDATA_W         = 32;
    localparam int OUT_TUSER_W         = 1;
    localparam int DEF_NUM_CHANNELS    = 8;
    localparam int DEF_BUFFER_ROWS     = 20;

    // Where the incoming word sits in the buffer.
    typedef struct packed {
        logic in_half;     // row belongs to one of the two halves
        logic end_first;   // last row of the first half
        logic end_second;  // last row of the second half
    } t_row_flags;

endpackage

[src/mhba_recip_div.sv]
// Unsigned division by an elaboration-time constant, by multiplying with a
// rounded-up reciprocal and shifting. Depends on nothing outside this file.
module mhba_recip_div #(
    parameter int DIVISOR = 10,
    parameter int IN_W    = 16,
    parameter int OUT_W   = 12
) (
    input  logic [IN_W-1:0]  i_num,
    output logic [OUT_W-1:0] o_quot
);

    // With L = ceil(log2(DIVISOR)) and a reciprocal rounded up over
    // IN_W + L fraction bits, the quotient is exact for every IN_W-bit input.
    localparam int    L_BITS = (DIVISOR > 1) ? $clog2(DIVISOR) : 0;
    localparam int    SHIFT  = IN_W + L_BITS;
    localparam int    M_W    = IN_W + 2;
    localparam int    PROD_W = IN_W + M_W;
    localparam longint RECIP_L = ((64'd1 << SHIFT) + DIVISOR - 1) / DIVISOR;
    localparam logic [M_W-1:0] RECIP = M_W'(RECIP_L);

    logic [PROD_W-1:0] w_prod;
    logic [PROD_W-1:0] w_shifted;

    assign w_prod    = PROD_W'(i_num) * PROD_W'(RECIP);
    assign w_shifted = w_prod >> SHIFT;
    assign o_quot    = OUT_W'(w_shifted);

endmodule

[src/multichannel_half_buffer_averager_core.sv]
// Multichannel half-buffer averager: per-channel sums over each buffer half,
// reported as truncated means. Depends on mhba_pkg and mhba_recip_div.
// An accepted word that ends a half passes from the input register stage into
// the output register once it is free. Throughput: one word per cycle, set by
// the single accumulate/divide stage, while no report waits on the output.
// Reset (synchronous, active low) clears sums, first-half means and position.
module multichannel_half_buffer_averager_core #(
    parameter int NUM_CHANNELS = mhba_pkg::DEF_NUM_CHANNELS,
    parameter int BUFFER_ROWS  = mhba_pkg::DEF_BUFFER_ROWS
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // [11:0] sample, [15:12] zero
    input  logic [mhba_pkg::IN_TDATA_W-1:0]  i_s_axis_tdata,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // [2:0] channel, [14:3] half_mean, [26:15] full_mean, [31:27] zero
    output logic [mhba_pkg::OUT_TDATA_W-1:0] o_m_axis_tdata,
    // [0] second_half
    output logic [mhba_pkg::OUT_TUSER_W-1:0] o_m_axis_tuser
);

    localparam int SW       = mhba_pkg::SAMPLE_W;
    localparam int HALF     = BUFFER_ROWS / 2;
    localparam int SLOT_W   = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int ROW_W    = $clog2(BUFFER_ROWS);
    localparam int SUM_W    = $clog2(4095 * HALF + 1);
    localparam logic [SLOT_W-1:0] LAST_SLOT  = SLOT_W'(NUM_CHANNELS - 1);
    localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(BUFFER_ROWS - 1);
    localparam logic [ROW_W-1:0]  END_FIRST  = ROW_W'(HALF - 1);
    localparam logic [ROW_W-1:0]  END_SECOND = ROW_W'(2 * HALF - 1);
    localparam int PAD_W = mhba_pkg::OUT_TDATA_W - mhba_pkg::CHAN_W - 2 * SW;

    // Buffer position of the next word.
    logic [SLOT_W-1:0] r_slot;
    logic [ROW_W-1:0]  r_row;

    // Input register stage.
    logic                 r_s1_valid;
    logic [SW-1:0]        r_s1_sample;
    logic [SLOT_W-1:0]    r_s1_slot;
    mhba_pkg::t_row_flags r_s1_flags;

    // Per-channel state.
    logic [SUM_W-1:0] r_sum   [NUM_CHANNELS];
    logic [SW-1:0]    r_first [NUM_CHANNELS];

    // Result register.
    logic                      r_out_valid;
    logic [mhba_pkg::CHAN_W-1:0] r_out_chan;
    logic [SW-1:0]             r_out_half;
    logic                      r_out_second;
    logic [SW-1:0]             r_out_full;

    logic                 w_accept;
    logic                 w_out_free;
    logic                 w_s1_report;
    logic                 w_s1_go;
    mhba_pkg::t_row_flags w_in_flags;
    logic [SUM_W-1:0]     w_new_sum;
    logic [SW-1:0]        w_mean;
    logic [SW:0]          w_pair;
    logic [SW-1:0]        w_full;

    assign w_out_free  = !r_out_valid || i_m_axis_tready;
    assign w_s1_report = r_s1_flags.end_first || r_s1_flags.end_second;
    assign w_s1_go     = r_s1_valid && (!w_s1_report || w_out_free);
    assign o_s_axis_tready = !r_s1_valid || w_s1_go;
    assign w_accept    = i_s_axis_tvalid && o_s_axis_tready;

    always_comb begin
        w_in_flags.in_half    = (r_row <= END_SECOND);
        w_in_flags.end_first  = (r_row == END_FIRST);
        w_in_flags.end_second = (r_row == END_SECOND);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot     <= '0;
            r_row      <= '0;
            r_s1_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                if (r_slot == LAST_SLOT) begin
                    r_slot <= '0;
                    r_row  <= (r_row == LAST_ROW) ? '0 : r_row + ROW_W'(1);
                end else begin
                    r_slot <= r_slot + SLOT_W'(1);
                end
                r_s1_valid <= 1'b1;
            end else if (w_s1_go) begin
                r_s1_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_sample <= i_s_axis_tdata[SW-1:0];
            r_s1_slot   <= r_slot;
            r_s1_flags  <= w_in_flags;
        end
    end

    assign w_new_sum = r_sum[r_s1_slot] + SUM_W'(r_s1_sample);

    mhba_recip_div #(
        .DIVISOR (HALF),
        .IN_W    (SUM_W),
        .OUT_W   (SW)
    ) u_div (
        .i_num  (w_new_sum),
        .o_quot (w_mean)
    );

    assign w_pair = (SW + 1)'(r_first[r_s1_slot]) + (SW + 1)'(w_mean);
    assign w_full = w_pair[SW:1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i]   <= '0;
                r_first[i] <= '0;
            end
        end else if (w_s1_go && r_s1_flags.in_half) begin
            // A channel's sum restarts once its half has been reported.
            r_sum[r_s1_slot] <= w_s1_report ? '0 : w_new_sum;
            if (r_s1_flags.end_first) begin
                r_first[r_s1_slot] <= w_mean;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_go && w_s1_report) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_go && w_s1_report) begin
            r_out_chan   <= mhba_pkg::CHAN_W'(r_s1_slot);
            r_out_half   <= w_mean;
            r_out_second <= r_s1_flags.end_second;
            r_out_full   <= r_s1_flags.end_second ? w_full : '0;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {{PAD_W{1'b0}}, r_out_full, r_out_half, r_out_chan};
    assign o_m_axis_tuser  = r_out_second;

endmodule
